### hw/rtl/rpd_pkg.sv
// Shared types and constants of the radial-to-planar depth converter.
package rpd_pkg;

    localparam int COORD_BITS = 12;
    localparam int Z_BITS     = 16;
    localparam int LATENCY    = 3 + Z_BITS;

    localparam int F_W    = 24;
    localparam int DX_W   = 24;
    localparam int NUM_W  = 40;
    localparam int HALF_W = NUM_W / 2;
    localparam int N2_W   = 2 * NUM_W;
    localparam int S_W    = 2 * DX_W + 2;
    localparam int T_W    = S_W + Z_BITS + 2;
    localparam int D_W    = S_W + 2 * Z_BITS + 2;

    localparam logic [1:0] CFG_FOCAL    = 2'd0;
    localparam logic [1:0] CFG_CENTER_X = 2'd1;
    localparam logic [1:0] CFG_CENTER_Y = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [N2_W-1:0]   r;
        logic [T_W-1:0]    t;
        logic [S_W-1:0]    s;
        logic [Z_BITS-1:0] z;
    } t_cell;

endpackage

### hw/rtl/rpd_front.sv
// Front pipeline: offsets, squares and the scaled sample square for the cell chain.
module rpd_front import rpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_depth,
    input  logic [11:0] i_col,
    input  logic [11:0] i_row,
    input  logic [23:0] i_focal,
    input  logic [15:0] i_cx,
    input  logic [15:0] i_cy,
    output t_cell       o_cell
);

    logic [DX_W-1:0] col_q8, row_q8, cx_q8, cy_q8, n_dx, n_dy;
    logic            r_v1, r_v2, r_v3, r_zero1, r_zero2;
    logic [DX_W-1:0] r_dx, r_dy;
    logic [NUM_W-1:0] r_num;
    logic [2*F_W-1:0] r_ff1, r_ff2;
    logic [2*DX_W-1:0] r_dx2, r_dy2;
    logic [2*HALF_W-1:0] r_hh, r_hl, r_ll;
    logic [N2_W-1:0] r_n2;
    logic [S_W-1:0]  r_s;

    assign col_q8 = DX_W'({i_col[COORD_BITS-1:0], 8'd0});
    assign row_q8 = DX_W'({i_row[COORD_BITS-1:0], 8'd0});
    assign cx_q8  = DX_W'({i_cx, 4'd0});
    assign cy_q8  = DX_W'({i_cy, 4'd0});
    assign n_dx   = (col_q8 >= cx_q8) ? col_q8 - cx_q8 : cx_q8 - col_q8;
    assign n_dy   = (row_q8 >= cy_q8) ? row_q8 - cy_q8 : cy_q8 - row_q8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_num   <= NUM_W'(i_focal * i_depth);
        r_ff1   <= i_focal * i_focal;
        r_zero1 <= (i_depth == 16'd0) || (i_focal == 24'd0);

        r_dx2   <= r_dx * r_dx;
        r_dy2   <= r_dy * r_dy;
        r_ff2   <= r_ff1;
        r_hh    <= r_num[NUM_W-1:HALF_W] * r_num[NUM_W-1:HALF_W];
        r_hl    <= r_num[NUM_W-1:HALF_W] * r_num[HALF_W-1:0];
        r_ll    <= r_num[HALF_W-1:0] * r_num[HALF_W-1:0];
        r_zero2 <= r_zero1;

        // A zero sample or zero focal length is steered to a zero result.
        if (r_zero2) begin
            r_n2 <= '0;
            r_s  <= S_W'(1);
        end else begin
            r_n2 <= (N2_W'(r_hh) << (2 * HALF_W)) + (N2_W'(r_hl) << (HALF_W + 1))
                    + N2_W'(r_ll);
            r_s  <= S_W'(r_dx2) + S_W'(r_dy2) + S_W'(r_ff2);
        end
    end

    always_comb begin
        o_cell       = '0;
        o_cell.valid = r_v3;
        o_cell.r     = r_n2;
        o_cell.s     = r_s;
    end

endmodule

### hw/rtl/rpd_cell.sv
// One cell of the chain: settles one bit of the result by trial subtraction.
module rpd_cell import rpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_bit,
    input  t_cell      i_cell,
    output t_cell      o_cell
);

    logic [D_W-1:0] delta;
    logic           take;
    t_cell          r_cell;

    // Growing z by 2^b adds S*(z*2^(b+1) + 2^(2b)) to z^2*S; T tracks z*S.
    assign delta = (D_W'(i_cell.t) << ({1'b0, i_bit} + 5'd1))
                 + (D_W'(i_cell.s) << ({i_bit, 1'b0}));
    assign take  = delta <= D_W'(i_cell.r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= i_cell.valid;
        end
        r_cell.s <= i_cell.s;
        if (take) begin
            r_cell.r <= i_cell.r - N2_W'(delta);
            r_cell.t <= i_cell.t + (T_W'(i_cell.s) << i_bit);
            r_cell.z <= i_cell.z | (Z_BITS'(1) << i_bit);
        end else begin
            r_cell.r <= i_cell.r;
            r_cell.t <= i_cell.t;
            r_cell.z <= i_cell.z;
        end
    end

    assign o_cell = r_cell;

endmodule

### hw/rtl/radial_to_planar_depth.sv
// Top level of the radial-to-planar depth converter.
//
//   channel   direction  handshake            payload
//   command   in         i_start / o_busy     depth sample, pixel column, pixel row
//   result    out        o_done strobe        planar depth
//   config    in         i_cfg_valid/ready    register index, write data
//
// A pixel enters every cycle; o_busy stays low. Each result passes through
// three front stages then one cell per result bit in a 16-cell chain.
// Reset is synchronous, active low, and restores the camera registers.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module radial_to_planar_depth import rpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_depth_sample,
    input  logic [11:0] i_pixel_col,
    input  logic [11:0] i_pixel_row,
    output logic        o_done,
    output logic [15:0] o_planar_depth,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [23:0] r_focal;
    logic [15:0] r_cx, r_cy;
    t_cell       chain [0:Z_BITS];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= 24'd133120;
            r_cx    <= 16'd5112;
            r_cy    <= 16'd3832;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOCAL:    r_focal <= i_cfg_data;
                CFG_CENTER_X: r_cx    <= i_cfg_data[15:0];
                CFG_CENTER_Y: r_cy    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    rpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_depth (i_depth_sample),
        .i_col   (i_pixel_col),
        .i_row   (i_pixel_row),
        .i_focal (r_focal),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_cell  (chain[0])
    );

    for (genvar k = 0; k < Z_BITS; k++) begin : g_cell
        rpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (4'(Z_BITS - 1 - k)),
            .i_cell  (chain[k]),
            .o_cell  (chain[k+1])
        );
    end

    assign o_done         = chain[Z_BITS].valid;
    assign o_planar_depth = chain[Z_BITS].z;

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LATENCY))
        else $error("result without a matching transaction");
    a_not_above_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_planar_depth <= $past(i_depth_sample, LATENCY))
        else $error("planar depth exceeds radial sample");
    a_zero_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_depth_sample, LATENCY) == 16'd0) |-> o_planar_depth == 16'd0)
        else $error("zero sample gave nonzero depth");
`endif

endmodule
